FILE: design/gsitr_pkg.sv
// gsitr_pkg: shared types, constants and register map of the gear and throttle controller
package gsitr_pkg;

  // gear codes as seen on the result channel
  typedef enum logic [1:0] {
    GEAR_P = 2'd0,
    GEAR_R = 2'd1,
    GEAR_N = 2'd2,
    GEAR_D = 2'd3
  } gear_t;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_COAST_PERIOD = 2'd0;
  localparam logic [1:0] REG_DRIVE_PERIOD = 2'd1;
  localparam logic [1:0] REG_DEAD_ZONE    = 2'd2;
  localparam logic [1:0] REG_MIN_DUTY     = 2'd3;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [15:0] COAST_PERIOD_RST = 16'd10;
  localparam logic [15:0] DRIVE_PERIOD_RST = 16'd10;
  localparam logic [6:0]  DEAD_ZONE_RST    = 7'd5;
  localparam logic [6:0]  MIN_DUTY_RST     = 7'd50;

  localparam int RAMP_COUNT_BITS_DEF = 16;

  // selector windows, exclusive bounds
  localparam logic [11:0] SEL_P_LO = 12'd4050;
  localparam logic [11:0] SEL_R_LO = 12'd3180;
  localparam logic [11:0] SEL_R_HI = 12'd3250;
  localparam logic [11:0] SEL_N_LO = 12'd2430;
  localparam logic [11:0] SEL_N_HI = 12'd2520;
  localparam logic [11:0] SEL_D_LO = 12'd1570;
  localparam logic [11:0] SEL_D_HI = 12'd1650;

  // throttle full scale of the adc
  localparam logic [12:0] THR_FULL_SCALE = 13'd4095;
  localparam logic [6:0]  PCT_FULL       = 7'd100;

  // x / 100 as (x * 5243) >> 19, exact for x below 43690
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  typedef struct packed {
    logic [15:0] coast_decay_period;
    logic [15:0] drive_ramp_period;
    logic [6:0]  dead_zone;
    logic [6:0]  min_duty;
  } cfg_regs_t;

  typedef struct packed {
    logic [11:0] selector_sample;
    logic        selector_valid;
    logic [11:0] throttle_sample;
    logic        throttle_valid;
    logic [15:0] pulse_count;
  } in_item_t;

  // controller state apart from the ramp counter
  typedef struct packed {
    gear_t       target_gear;
    gear_t       accepted_gear;
    gear_t       last_drive_dir;
    logic [6:0]  throttle_pct;
    logic [6:0]  ramped_throttle;
    logic [11:0] last_selector;
  } ctl_state_t;

  // per-tick result before duty scaling
  typedef struct packed {
    gear_t      current_gear;
    gear_t      requested_gear;
    logic       forward_pin;
    logic       reverse_pin;
    logic       motor_on;
    logic [6:0] active_throttle;
  } tick_res_t;

endpackage

FILE: design/gsitr_if.sv
// gsitr_if: valid/ready channel interfaces for tick samples and results
interface gsitr_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] selector_sample;
  logic        selector_valid;
  logic [11:0] throttle_sample;
  logic        throttle_valid;
  logic [15:0] pulse_count;

  modport source (output valid, selector_sample, selector_valid, throttle_sample,
                  throttle_valid, pulse_count, input ready);
  modport sink   (input valid, selector_sample, selector_valid, throttle_sample,
                  throttle_valid, pulse_count, output ready);
endinterface

interface gsitr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] current_gear;
  logic [1:0] requested_gear;
  logic       forward_pin;
  logic       reverse_pin;
  logic [6:0] pwm_duty;
  logic [6:0] active_throttle;

  modport source (output valid, current_gear, requested_gear, forward_pin, reverse_pin,
                  pwm_duty, active_throttle, input ready);
  modport sink   (input valid, current_gear, requested_gear, forward_pin, reverse_pin,
                  pwm_duty, active_throttle, output ready);
endinterface

FILE: design/gear_shift_inhibit_throttle_ramp.sv
// gear_shift_inhibit_throttle_ramp: gear selector decode, shift inhibit and throttle ramp
//
//   channel   direction  handshake                 transfer carries
//   in_ch     sink       valid/ready               selector, throttle, pulse count
//   out_ch    source     valid/ready               gears, pins, pwm duty, throttle
//   cfg_*     slave      apb write at access phase periods, dead zone, min duty
//
// one tick transfer in and one result out per cycle, sustained while out_ch takes each result
// a tick taken on in_ch shows on out_ch after passing through these registers in order
// (input register, state/product register, result register)
// the whole pipe moves together and holds only while out_ch is full and not taken,
// so in_ch.ready follows the result register alone
// synchronous active-low reset: registers to reset values, gear park, pipe empty
module gear_shift_inhibit_throttle_ramp #(
  parameter int RAMP_COUNT_BITS = gsitr_pkg::RAMP_COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  gsitr_in_if.sink                          in_ch,
  gsitr_out_if.source                       out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [gsitr_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [gsitr_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [gsitr_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);

  gsitr_pkg::cfg_regs_t       cfg;

  // pipe advance: whole pipe moves unless a result sits untaken
  logic                       adv;

  // stage 1: registered tick sample
  logic                       s1_vld_r;
  gsitr_pkg::in_item_t        s1_item_r;
  gsitr_pkg::in_item_t        in_item;

  // controller state
  gsitr_pkg::ctl_state_t      st_r;
  gsitr_pkg::ctl_state_t      st_nxt;
  logic [RAMP_COUNT_BITS-1:0] cnt_r;
  logic [RAMP_COUNT_BITS-1:0] cnt_nxt;
  gsitr_pkg::tick_res_t       tick_res;

  // stage 2: tick result and throttle*(100-m) product
  logic                       s2_vld_r;
  gsitr_pkg::tick_res_t       s2_res_r;
  logic [13:0]                s2_prod_r;
  logic [6:0]                 s2_min_r;
  logic [6:0]                 min_clamp;
  logic [6:0]                 span;

  // result register
  logic                       out_vld_r;
  gsitr_pkg::tick_res_t       out_res_r;
  logic [6:0]                 out_duty_r;
  logic [26:0]                div_prod;
  logic [6:0]                 duty_nxt;

  gsitr_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign in_item.selector_sample = in_ch.selector_sample;
  assign in_item.selector_valid  = in_ch.selector_valid;
  assign in_item.throttle_sample = in_ch.throttle_sample;
  assign in_item.throttle_valid  = in_ch.throttle_valid;
  assign in_item.pulse_count     = in_ch.pulse_count;

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ch.valid) begin
      s1_item_r <= in_item;
    end
  end

  // one tick of decode, inhibit and ramp against the current state
  gsitr_tick #(
    .RAMP_COUNT_BITS (RAMP_COUNT_BITS)
  ) u_tick (
    .item    (s1_item_r),
    .st      (st_r),
    .cnt     (cnt_r),
    .cfg     (cfg),
    .st_nxt  (st_nxt),
    .cnt_nxt (cnt_nxt),
    .res     (tick_res)
  );

  // state only commits when the tick moves on to stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.target_gear     <= gsitr_pkg::GEAR_P;
      st_r.accepted_gear   <= gsitr_pkg::GEAR_P;
      st_r.last_drive_dir  <= gsitr_pkg::GEAR_P;
      st_r.throttle_pct    <= 7'd0;
      st_r.ramped_throttle <= 7'd0;
      st_r.last_selector   <= 12'd0;
      cnt_r                <= '0;
      s2_vld_r             <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
      if (s1_vld_r) begin
        st_r  <= st_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // minimum duty limited to full scale; duty span above it
  assign min_clamp = (cfg.min_duty > gsitr_pkg::PCT_FULL) ? gsitr_pkg::PCT_FULL
                                                          : cfg.min_duty;
  assign span      = gsitr_pkg::PCT_FULL - min_clamp;

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      s2_res_r  <= tick_res;
      s2_prod_r <= 14'(tick_res.active_throttle) * 14'(span);
      s2_min_r  <= min_clamp;
    end
  end

  // product / 100 by reciprocal multiply, then offset by the minimum duty
  assign div_prod = 27'(s2_prod_r) * 27'(gsitr_pkg::DIV100_MUL);
  assign duty_nxt = s2_res_r.motor_on ? s2_min_r + 7'(div_prod >> gsitr_pkg::DIV100_SHIFT)
                                      : 7'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r) begin
      out_res_r  <= s2_res_r;
      out_duty_r <= duty_nxt;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.current_gear    = out_res_r.current_gear;
  assign out_ch.requested_gear  = out_res_r.requested_gear;
  assign out_ch.forward_pin     = out_res_r.forward_pin;
  assign out_ch.reverse_pin     = out_res_r.reverse_pin;
  assign out_ch.pwm_duty        = out_duty_r;
  assign out_ch.active_throttle = out_res_r.active_throttle;

endmodule

FILE: design/gsitr_cfg_regs.sv
// gsitr_cfg_regs: apb register file for ramp periods, dead zone and minimum duty
module gsitr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [gsitr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [gsitr_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [gsitr_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready,
  output gsitr_pkg::cfg_regs_t                cfg
);

  gsitr_pkg::cfg_regs_t regs_r;
  logic                 wr_en;
  logic [1:0]           reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.coast_decay_period <= gsitr_pkg::COAST_PERIOD_RST;
      regs_r.drive_ramp_period  <= gsitr_pkg::DRIVE_PERIOD_RST;
      regs_r.dead_zone          <= gsitr_pkg::DEAD_ZONE_RST;
      regs_r.min_duty           <= gsitr_pkg::MIN_DUTY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        gsitr_pkg::REG_COAST_PERIOD: regs_r.coast_decay_period <= cfg_pwdata[15:0];
        gsitr_pkg::REG_DRIVE_PERIOD: regs_r.drive_ramp_period  <= cfg_pwdata[15:0];
        gsitr_pkg::REG_DEAD_ZONE:    regs_r.dead_zone          <= cfg_pwdata[6:0];
        gsitr_pkg::REG_MIN_DUTY:     regs_r.min_duty           <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gsitr_pkg::REG_COAST_PERIOD: cfg_prdata = 32'(regs_r.coast_decay_period);
      gsitr_pkg::REG_DRIVE_PERIOD: cfg_prdata = 32'(regs_r.drive_ramp_period);
      gsitr_pkg::REG_DEAD_ZONE:    cfg_prdata = 32'(regs_r.dead_zone);
      gsitr_pkg::REG_MIN_DUTY:     cfg_prdata = 32'(regs_r.min_duty);
      default:                     cfg_prdata = '0;
    endcase
  end

endmodule

FILE: design/gsitr_tick.sv
// gsitr_tick: next-state logic for one control tick (decode, inhibit, ramp, direction)
module gsitr_tick #(
  parameter int RAMP_COUNT_BITS = gsitr_pkg::RAMP_COUNT_BITS_DEF
) (
  input  gsitr_pkg::in_item_t           item,
  input  gsitr_pkg::ctl_state_t         st,
  input  logic [RAMP_COUNT_BITS-1:0]    cnt,
  input  gsitr_pkg::cfg_regs_t          cfg,
  output gsitr_pkg::ctl_state_t         st_nxt,
  output logic [RAMP_COUNT_BITS-1:0]    cnt_nxt,
  output gsitr_pkg::tick_res_t          res
);

  localparam int CW = (RAMP_COUNT_BITS > 16) ? RAMP_COUNT_BITS : 16;
  localparam logic [RAMP_COUNT_BITS-1:0] CNT_MAX = {RAMP_COUNT_BITS{1'b1}};

  logic [11:0]                sel;
  gsitr_pkg::gear_t           tgt;
  logic [18:0]                thr_x100;
  logic [6:0]                 q0;
  logic [12:0]                rem;
  logic [6:0]                 thr;
  logic                       calm;
  gsitr_pkg::gear_t           acc;
  logic [RAMP_COUNT_BITS-1:0] cnt_inc;
  logic [CW-1:0]              cnt_ext;
  logic [CW-1:0]              coast_ext;
  logic [CW-1:0]              drive_ext;
  logic [6:0]                 ramped;
  gsitr_pkg::gear_t           dir;
  logic                       on;

  // selector decode, windows checked park first
  always_comb begin
    sel = item.selector_valid ? item.selector_sample : st.last_selector;
    tgt = st.target_gear;
    if (sel > gsitr_pkg::SEL_P_LO) begin
      tgt = gsitr_pkg::GEAR_P;
    end else if (sel > gsitr_pkg::SEL_R_LO && sel < gsitr_pkg::SEL_R_HI) begin
      tgt = gsitr_pkg::GEAR_R;
    end else if (sel > gsitr_pkg::SEL_N_LO && sel < gsitr_pkg::SEL_N_HI) begin
      tgt = gsitr_pkg::GEAR_N;
    end else if (sel > gsitr_pkg::SEL_D_LO && sel < gsitr_pkg::SEL_D_HI) begin
      tgt = gsitr_pkg::GEAR_D;
    end
  end

  // sample*100/4095: split at 4096, remainder stays below twice the divisor
  always_comb begin
    thr_x100 = {1'b0, item.throttle_sample, 6'b0} + {2'b0, item.throttle_sample, 5'b0}
             + {5'b0, item.throttle_sample, 2'b0};
    q0  = thr_x100[18:12];
    rem = {1'b0, thr_x100[11:0]} + {6'b0, q0};
    if (!item.throttle_valid) begin
      thr = st.throttle_pct;
    end else if (rem >= gsitr_pkg::THR_FULL_SCALE) begin
      thr = q0 + 7'd1;
    end else begin
      thr = q0;
    end
  end

  // shift inhibit
  always_comb begin
    calm = (item.pulse_count == 16'd0) && (thr < cfg.dead_zone);
    acc  = st.accepted_gear;
    if (st.accepted_gear != tgt) begin
      case (tgt)
        gsitr_pkg::GEAR_N: acc = gsitr_pkg::GEAR_N;
        gsitr_pkg::GEAR_P, gsitr_pkg::GEAR_R: begin
          if (calm) acc = tgt;
        end
        default: begin
          if (calm || (st.accepted_gear == gsitr_pkg::GEAR_N &&
                       st.last_drive_dir == gsitr_pkg::GEAR_D)) begin
            acc = gsitr_pkg::GEAR_D;
          end
        end
      endcase
    end
  end

  // saturating ramp counter and gear-dependent throttle filter
  always_comb begin
    cnt_inc   = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
    cnt_ext   = CW'(cnt_inc);
    coast_ext = CW'(cfg.coast_decay_period);
    drive_ext = CW'(cfg.drive_ramp_period);
    cnt_nxt   = cnt_inc;
    ramped    = st.ramped_throttle;
    case (acc)
      gsitr_pkg::GEAR_N: begin
        if (cnt_ext >= coast_ext) begin
          cnt_nxt = '0;
          if (ramped != 7'd0) ramped = ramped - 7'd1;
        end
      end
      gsitr_pkg::GEAR_D: begin
        if (cnt_ext >= drive_ext) begin
          cnt_nxt = '0;
          if (ramped < thr) ramped = ramped + 7'd1;
          else if (ramped > thr) ramped = thr;
        end
      end
      gsitr_pkg::GEAR_R: ramped = thr;
      default:           ramped = 7'd0;
    endcase
  end

  // direction pins
  always_comb begin
    dir = st.last_drive_dir;
    if (acc == gsitr_pkg::GEAR_D || acc == gsitr_pkg::GEAR_R) dir = acc;
    on = (acc != gsitr_pkg::GEAR_P) && (ramped >= cfg.dead_zone);
    res.current_gear    = acc;
    res.requested_gear  = tgt;
    res.motor_on        = on;
    res.forward_pin     = on && (acc == gsitr_pkg::GEAR_D ||
                                 (acc == gsitr_pkg::GEAR_N && dir == gsitr_pkg::GEAR_D));
    res.reverse_pin     = on && (acc == gsitr_pkg::GEAR_R ||
                                 (acc == gsitr_pkg::GEAR_N && dir != gsitr_pkg::GEAR_D));
    res.active_throttle = ramped;

    st_nxt.target_gear     = tgt;
    st_nxt.accepted_gear   = acc;
    st_nxt.last_drive_dir  = dir;
    st_nxt.throttle_pct    = thr;
    st_nxt.ramped_throttle = ramped;
    st_nxt.last_selector   = sel;
  end

endmodule

FILE: design/gsitr_checker.sv
// gsitr_checker: port-level assertions for the gear and throttle controller, with its bind
module gsitr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] current_gear,
  input logic       forward_pin,
  input logic       reverse_pin,
  input logic [6:0] pwm_duty,
  input logic [6:0] active_throttle
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(current_gear) && $stable(pwm_duty)
      && $stable(active_throttle))
    else $error("result changed while stalled");

  // bridge never driven both ways
  a_pins_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(forward_pin && reverse_pin))
    else $error("both direction pins set");

  // park keeps the motor off
  a_park_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && current_gear == gsitr_pkg::GEAR_P |-> !forward_pin && !reverse_pin
      && pwm_duty == 7'd0 && active_throttle == 7'd0)
    else $error("motor driven in park");

  // drive only forward, reverse only reverse
  a_dir_gear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(current_gear == gsitr_pkg::GEAR_D && reverse_pin)
      && !(current_gear == gsitr_pkg::GEAR_R && forward_pin))
    else $error("direction pin against gear");

  // percentages stay in range
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pwm_duty <= 7'd100 && active_throttle <= 7'd100)
    else $error("percent out of range");

endmodule

bind gear_shift_inhibit_throttle_ramp gsitr_checker u_gsitr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .current_gear    (out_ch.current_gear),
  .forward_pin     (out_ch.forward_pin),
  .reverse_pin     (out_ch.reverse_pin),
  .pwm_duty        (out_ch.pwm_duty),
  .active_throttle (out_ch.active_throttle)
);

FILE: sim/tb.sv
// tb: self-checking bench for the gear selector, shift inhibit and throttle ramp block
module tb;

  // one result transfer as the bench expects it
  typedef struct packed {
    gsitr_pkg::gear_t cur_gear;
    gsitr_pkg::gear_t req_gear;
    logic             fwd;
    logic             rev;
    logic [6:0]       duty;
    logic [6:0]       thr;
  } drive_out_t;

  // directed row: tick to send, and a hand-typed result where it is obvious
  typedef struct packed {
    gsitr_pkg::in_item_t tick;
    logic                typed;
    drive_out_t          want;
  } tick_row_t;

  // one register setting for a phase of random ticks
  typedef struct packed {
    logic [15:0] coast;
    logic [15:0] drive;
    logic [6:0]  dead;
    logic [6:0]  minp;
  } reg_set_t;

  localparam int RCB        = gsitr_pkg::RAMP_COUNT_BITS_DEF;
  localparam int IDLE_LIMIT = 1000;
  localparam int N_RAND     = 270;
  localparam int MAX_LINES  = 50;

  localparam drive_out_t NO_WANT    = '0;
  localparam drive_out_t PARKED_OFF = '{gsitr_pkg::GEAR_P, gsitr_pkg::GEAR_P,
                                        1'b0, 1'b0, 7'd0, 7'd0};
  localparam drive_out_t REV_HELD   = '{gsitr_pkg::GEAR_P, gsitr_pkg::GEAR_R,
                                        1'b0, 1'b0, 7'd0, 7'd0};

  logic clk = 1'b0;
  logic rst_n;

  gsitr_in_if  in_ch();
  gsitr_out_if out_ch();

  logic                             cfg_psel;
  logic                             cfg_penable;
  logic                             cfg_pwrite;
  logic [gsitr_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [gsitr_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [gsitr_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                             cfg_pready;

  gear_shift_inhibit_throttle_ramp dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor copy of the register file, starting from reset values
  logic [15:0] coast_per = gsitr_pkg::COAST_PERIOD_RST;
  logic [15:0] drive_per = gsitr_pkg::DRIVE_PERIOD_RST;
  logic [6:0]  dead_pct  = gsitr_pkg::DEAD_ZONE_RST;
  logic [6:0]  min_pct   = gsitr_pkg::MIN_DUTY_RST;

  // predictor copy of the controller state
  gsitr_pkg::gear_t tgt_gear  = gsitr_pkg::GEAR_P;
  gsitr_pkg::gear_t acc_gear  = gsitr_pkg::GEAR_P;
  gsitr_pkg::gear_t drive_dir = gsitr_pkg::GEAR_P;
  logic [6:0]       thr_pct   = '0;
  logic [6:0]       ramp_thr  = '0;
  logic [RCB-1:0]   ramp_cnt  = '0;
  logic [11:0]      sel_hold  = '0;

  drive_out_t       pending_out[$];   // results still owed by the block, oldest first
  int               errs        = 0;
  int               idle_cycles = 0;
  bit               no_idle     = 1'b0;
  gsitr_pkg::gear_t aim_gear    = gsitr_pkg::GEAR_P;

  // directed ticks from reset values: window edges, inhibit cases, every gear
  tick_row_t directed_ticks [24] = '{
    // nothing valid yet: park, motor off
    '{'{12'd0,    1'b0, 12'd0,    1'b0, 16'd0},     1'b1, PARKED_OFF},
    // full scale everywhere, still parked
    '{'{12'd4095, 1'b1, 12'd4095, 1'b1, 16'd65535}, 1'b1, PARKED_OFF},
    // window bounds are exclusive, request held
    '{'{12'd4050, 1'b1, 12'd0,    1'b1, 16'd0},     1'b1, PARKED_OFF},
    '{'{12'd3250, 1'b1, 12'd2048, 1'b1, 16'd0},     1'b1, PARKED_OFF},
    // reverse refused: throttle open, then wheels turning
    '{'{12'd3200, 1'b1, 12'd4095, 1'b1, 16'd0},     1'b1, REV_HELD},
    '{'{12'd3181, 1'b1, 12'd0,    1'b1, 16'd1},     1'b1, REV_HELD},
    // reverse taken when stopped and throttle shut
    '{'{12'd3249, 1'b1, 12'd0,    1'b1, 16'd0},     1'b1,
      '{gsitr_pkg::GEAR_R, gsitr_pkg::GEAR_R, 1'b0, 1'b0, 7'd0, 7'd0}},
    // reverse passes throttle straight through; stale selector sample ignored
    '{'{12'd1234, 1'b0, 12'd4095, 1'b1, 16'd7},     1'b1,
      '{gsitr_pkg::GEAR_R, gsitr_pkg::GEAR_R, 1'b0, 1'b1, 7'd100, 7'd100}},
    // just on and just under the dead zone
    '{'{12'd0,    1'b0, 12'd205,  1'b1, 16'd7},     1'b1,
      '{gsitr_pkg::GEAR_R, gsitr_pkg::GEAR_R, 1'b0, 1'b1, 7'd52, 7'd5}},
    '{'{12'd0,    1'b0, 12'd204,  1'b1, 16'd7},     1'b1,
      '{gsitr_pkg::GEAR_R, gsitr_pkg::GEAR_R, 1'b0, 1'b0, 7'd0, 7'd4}},
    // neutral always taken, decay starts
    '{'{12'd2431, 1'b1, 12'd4095, 1'b1, 16'd100},   1'b0, NO_WANT},
    // drive from neutral refused: last direction was reverse, wheels turning
    '{'{12'd1600, 1'b1, 12'd0,    1'b0, 16'd50},    1'b0, NO_WANT},
    // drive taken once calm
    '{'{12'd1600, 1'b0, 12'd0,    1'b1, 16'd0},     1'b0, NO_WANT},
    '{'{12'd1571, 1'b1, 12'd4095, 1'b1, 16'd9},     1'b0, NO_WANT},
    '{'{12'd1571, 1'b1, 12'd4095, 1'b1, 16'd9},     1'b0, NO_WANT},
    '{'{12'd1571, 1'b1, 12'd4095, 1'b1, 16'd9},     1'b0, NO_WANT},
    // coast in neutral after drive, forward pin kept
    '{'{12'd2519, 1'b1, 12'd0,    1'b0, 16'd9},     1'b0, NO_WANT},
    // back into drive while moving, allowed by last direction
    '{'{12'd1649, 1'b1, 12'd4095, 1'b1, 16'd9},     1'b0, NO_WANT},
    // remaining window edges hold the request
    '{'{12'd1650, 1'b1, 12'd4095, 1'b1, 16'd9},     1'b0, NO_WANT},
    '{'{12'd1570, 1'b1, 12'd4095, 1'b1, 16'd9},     1'b0, NO_WANT},
    '{'{12'd2430, 1'b1, 12'd4095, 1'b1, 16'd9},     1'b0, NO_WANT},
    '{'{12'd2520, 1'b1, 12'd4095, 1'b1, 16'd9},     1'b0, NO_WANT},
    // park refused while moving, then taken once stopped
    '{'{12'd4051, 1'b1, 12'd4095, 1'b1, 16'd9},     1'b0, NO_WANT},
    '{'{12'd4051, 1'b0, 12'd0,    1'b1, 16'd0},     1'b1, PARKED_OFF}
  };

  // register settings per random phase, extremes included
  reg_set_t reg_plan [6] = '{
    '{16'd1,     16'd1,     7'd0,   7'd0},    // step each tick, no dead zone
    '{16'd0,     16'd0,     7'd100, 7'd100},  // zero periods, top of range
    '{16'd3,     16'd7,     7'd127, 7'd127},  // raw values past 100
    '{16'hFFFF,  16'hFFFF,  7'd20,  7'd75},   // longest periods
    '{16'd2,     16'd5,     7'd12,  7'd1},
    '{16'd10,    16'd10,    7'd5,   7'd50}    // back to reset values
  };

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (errs < MAX_LINES)
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    errs++;
  endtask

  // one control tick through the predictor, updating its state
  function automatic drive_out_t tick_predict(input gsitr_pkg::in_item_t t);
    drive_out_t r;
    logic       calm;
    int         m;
    if (t.selector_valid) sel_hold = t.selector_sample;
    // park window's upper bound is past the 12-bit range
    if (sel_hold > gsitr_pkg::SEL_P_LO) tgt_gear = gsitr_pkg::GEAR_P;
    else if (sel_hold > gsitr_pkg::SEL_R_LO && sel_hold < gsitr_pkg::SEL_R_HI)
      tgt_gear = gsitr_pkg::GEAR_R;
    else if (sel_hold > gsitr_pkg::SEL_N_LO && sel_hold < gsitr_pkg::SEL_N_HI)
      tgt_gear = gsitr_pkg::GEAR_N;
    else if (sel_hold > gsitr_pkg::SEL_D_LO && sel_hold < gsitr_pkg::SEL_D_HI)
      tgt_gear = gsitr_pkg::GEAR_D;

    if (t.throttle_valid) thr_pct = 7'((int'(t.throttle_sample) * 100) / 4095);

    // shift inhibit
    calm = (t.pulse_count == 16'd0) && (thr_pct < dead_pct);
    if (acc_gear != tgt_gear) begin
      case (tgt_gear)
        gsitr_pkg::GEAR_N: acc_gear = gsitr_pkg::GEAR_N;
        gsitr_pkg::GEAR_P, gsitr_pkg::GEAR_R: if (calm) acc_gear = tgt_gear;
        default: if (calm || (acc_gear == gsitr_pkg::GEAR_N &&
                              drive_dir == gsitr_pkg::GEAR_D)) acc_gear = gsitr_pkg::GEAR_D;
      endcase
    end

    // ramp filter, counter sticks at its ceiling
    if (ramp_cnt != '1) ramp_cnt++;
    case (acc_gear)
      gsitr_pkg::GEAR_N: if (ramp_cnt >= coast_per) begin
        ramp_cnt = '0;
        if (ramp_thr != 7'd0) ramp_thr--;
      end
      gsitr_pkg::GEAR_D: if (ramp_cnt >= drive_per) begin
        ramp_cnt = '0;
        if (ramp_thr < thr_pct) ramp_thr++;
        else ramp_thr = thr_pct;
      end
      gsitr_pkg::GEAR_R: ramp_thr = thr_pct;
      default: ramp_thr = '0;
    endcase

    if (acc_gear == gsitr_pkg::GEAR_D || acc_gear == gsitr_pkg::GEAR_R) drive_dir = acc_gear;

    r = '0;
    r.cur_gear = acc_gear;
    r.req_gear = tgt_gear;
    r.thr = ramp_thr;
    if (acc_gear != gsitr_pkg::GEAR_P && ramp_thr >= dead_pct) begin
      m = (min_pct > 7'd100) ? 100 : int'(min_pct);
      r.duty = 7'(m + int'(ramp_thr) * (100 - m) / 100);
      // neutral keeps the direction of the last drive or reverse spell
      r.fwd = (acc_gear == gsitr_pkg::GEAR_D) ||
              (acc_gear == gsitr_pkg::GEAR_N && drive_dir == gsitr_pkg::GEAR_D);
      r.rev = !r.fwd;
    end
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // random tick: mostly a held gear choice with in-window selector samples
  function automatic gsitr_pkg::in_item_t draw_tick();
    gsitr_pkg::in_item_t t;
    int                  r;
    if ($urandom_range(0, 15) == 0) aim_gear = gsitr_pkg::gear_t'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 8) begin
      t.selector_sample = 12'($urandom_range(0, 4095));
    end else if (r < 13) begin
      // exclusive window edges
      case ($urandom_range(0, 6))
        0: t.selector_sample = gsitr_pkg::SEL_P_LO;
        1: t.selector_sample = gsitr_pkg::SEL_R_LO;
        2: t.selector_sample = gsitr_pkg::SEL_R_HI;
        3: t.selector_sample = gsitr_pkg::SEL_N_LO;
        4: t.selector_sample = gsitr_pkg::SEL_N_HI;
        5: t.selector_sample = gsitr_pkg::SEL_D_LO;
        default: t.selector_sample = gsitr_pkg::SEL_D_HI;
      endcase
    end else begin
      case (aim_gear)
        gsitr_pkg::GEAR_P: t.selector_sample =
          12'($urandom_range(gsitr_pkg::SEL_P_LO + 1, 4095));
        gsitr_pkg::GEAR_R: t.selector_sample =
          12'($urandom_range(gsitr_pkg::SEL_R_LO + 1, gsitr_pkg::SEL_R_HI - 1));
        gsitr_pkg::GEAR_N: t.selector_sample =
          12'($urandom_range(gsitr_pkg::SEL_N_LO + 1, gsitr_pkg::SEL_N_HI - 1));
        default: t.selector_sample =
          12'($urandom_range(gsitr_pkg::SEL_D_LO + 1, gsitr_pkg::SEL_D_HI - 1));
      endcase
    end
    t.selector_valid = ($urandom_range(0, 9) != 0);

    r = $urandom_range(0, 99);
    if (r < 30) t.throttle_sample = 12'($urandom_range(0, 300));
    else if (r < 40) t.throttle_sample = 12'd4095;
    else if (r < 50) t.throttle_sample = 12'd0;
    else t.throttle_sample = 12'($urandom_range(0, 4095));
    t.throttle_valid = ($urandom_range(0, 7) != 0);

    r = $urandom_range(0, 99);
    if (r < 45) t.pulse_count = 16'd0;
    else if (r < 75) t.pulse_count = 16'($urandom_range(1, 20));
    else t.pulse_count = 16'($urandom_range(0, 65535));
    return t;
  endfunction

  // present one tick, wait for its transfer, then book the owed result
  task automatic push_tick(input gsitr_pkg::in_item_t t, input logic typed,
                           input drive_out_t want);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.selector_sample <= t.selector_sample;
    in_ch.selector_valid  <= t.selector_valid;
    in_ch.throttle_sample <= t.throttle_sample;
    in_ch.throttle_valid  <= t.throttle_valid;
    in_ch.pulse_count     <= t.pulse_count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // the predictor always runs so its state follows the block
    want = typed ? want : tick_predict(t);
    if (typed) void'(tick_predict(t));
    pending_out.push_back(want);
  endtask

  // stop sending and let every owed result come back, plus the pipe depth
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // apb write with random upper data bits, then read back the stored value
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    logic [31:0] wdata;
    logic [31:0] keep;
    wdata = $urandom;
    if (idx == gsitr_pkg::REG_COAST_PERIOD || idx == gsitr_pkg::REG_DRIVE_PERIOD) begin
      wdata[15:0] = val;
      keep = wdata & 32'hFFFF;
    end else begin
      wdata[6:0] = val[6:0];
      keep = wdata & 32'h7F;
    end
    case (idx)
      gsitr_pkg::REG_COAST_PERIOD: coast_per = keep[15:0];
      gsitr_pkg::REG_DRIVE_PERIOD: drive_per = keep[15:0];
      gsitr_pkg::REG_DEAD_ZONE:    dead_pct  = keep[6:0];
      default:                     min_pct   = keep[6:0];
    endcase

    // setup then access phase of the write
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);

    // read back the same register
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== keep) flag_mismatch("register readback", int'(cfg_prdata), int'(keep));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // result side: ready held high for runs and dropped for stalls of random length
  initial begin
    int   left;
    logic lvl;
    left = 0;
    lvl  = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        lvl  = !lvl;
        left = lvl ? $urandom_range(1, 8) : pick_gap();
        if (left == 0) begin
          lvl  = 1'b1;
          left = $urandom_range(1, 8);
        end
      end
      left--;
      out_ch.ready <= no_idle || lvl;
    end
  end

  // every result transfer is matched against the oldest owed result
  always @(posedge clk) begin
    drive_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_out.size() == 0) begin
        flag_mismatch("result with nothing owed, current_gear", out_ch.current_gear, 0);
      end else begin
        want = pending_out.pop_front();
        if (out_ch.current_gear !== want.cur_gear)
          flag_mismatch("current_gear", out_ch.current_gear, want.cur_gear);
        if (out_ch.requested_gear !== want.req_gear)
          flag_mismatch("requested_gear", out_ch.requested_gear, want.req_gear);
        if (out_ch.forward_pin !== want.fwd)
          flag_mismatch("forward_pin", out_ch.forward_pin, want.fwd);
        if (out_ch.reverse_pin !== want.rev)
          flag_mismatch("reverse_pin", out_ch.reverse_pin, want.rev);
        if (out_ch.pwm_duty !== want.duty)
          flag_mismatch("pwm_duty", out_ch.pwm_duty, want.duty);
        if (out_ch.active_throttle !== want.thr)
          flag_mismatch("active_throttle", out_ch.active_throttle, want.thr);
      end
    end
  end

  // watchdog: too long with no transfer on any port ends the run
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    // known values on every input from the first instant
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.selector_sample = '0;
    in_ch.selector_valid  = 1'b0;
    in_ch.throttle_sample = '0;
    in_ch.throttle_valid  = 1'b0;
    in_ch.pulse_count     = '0;
    cfg_psel              = 1'b0;
    cfg_penable           = 1'b0;
    cfg_pwrite            = 1'b0;
    cfg_paddr             = '0;
    cfg_pwdata            = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed ticks at reset register values
    foreach (directed_ticks[i])
      push_tick(directed_ticks[i].tick, directed_ticks[i].typed, directed_ticks[i].want);

    foreach (reg_plan[p]) begin
      // registers change only with the pipe empty
      wait_drained();
      cfg_write(gsitr_pkg::REG_COAST_PERIOD, reg_plan[p].coast);
      cfg_write(gsitr_pkg::REG_DRIVE_PERIOD, reg_plan[p].drive);
      cfg_write(gsitr_pkg::REG_DEAD_ZONE, {9'd0, reg_plan[p].dead});
      cfg_write(gsitr_pkg::REG_MIN_DUTY, {9'd0, reg_plan[p].minp});

      // random ticks, with one stretch in four free of any idling
      for (int k = 0; k < N_RAND; k++) begin
        no_idle = ((k / 64) % 4) == 1;
        push_tick(draw_tick(), 1'b0, NO_WANT);
      end
      no_idle = 1'b0;
    end

    wait_drained();
    if (errs == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
